FILE: design/dpr_pkg.sv
`timescale 1ns / 1ps

package dpr_pkg;

	localparam int DEPTH_DEF     = 64;
	localparam int ITEM_BITS_DEF = 32;

	// Width of positions and counts broadcast to the cells, wide enough for the largest depth.
	localparam int CTL_W = 13;

	localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
	localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
	localparam logic [3:0] OP_INSERT     = 4'd2;
	localparam logic [3:0] OP_POP_FRONT  = 4'd3;
	localparam logic [3:0] OP_POP_BACK   = 4'd4;
	localparam logic [3:0] OP_REMOVE     = 4'd5;
	localparam logic [3:0] OP_ROTATE     = 4'd6;
	localparam logic [3:0] OP_REV_FRONT  = 4'd7;
	localparam logic [3:0] OP_REV_BACK   = 4'd8;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic [2:0] MODE_HOLD   = 3'd0;
	localparam logic [2:0] MODE_INSERT = 3'd1;
	localparam logic [2:0] MODE_REMOVE = 3'd2;
	localparam logic [2:0] MODE_ROTATE = 3'd3;
	localparam logic [2:0] MODE_SWAP   = 3'd4;

	typedef struct packed {
		logic [3:0]  op;
		logic [31:0] item;
		logic [5:0]  position;
		logic [6:0]  span;
	} cmd_t;

	typedef struct packed {
		logic [31:0] touched_item;
		logic [1:0]  status;
		logic [6:0]  length;
	} rsp_t;

	typedef struct packed {
		logic [2:0]       mode;
		logic [CTL_W-1:0] at;
		logic [CTL_W-1:0] tail;
		logic [CTL_W-1:0] lo;
		logic [CTL_W-1:0] hi;
		logic             odd;
		logic             pick;
		logic             load;
	} ctl_t;

endpackage

FILE: design/dpr_cell.sv
`timescale 1ns / 1ps

module dpr_cell import dpr_pkg::*; #(
	parameter int IDX       = 0,
	parameter int ITEM_BITS = ITEM_BITS_DEF
) (
	input  logic                 clk,
	input  ctl_t                 ctl,
	input  logic [ITEM_BITS-1:0] item,
	input  logic [ITEM_BITS-1:0] head_d,
	input  logic [ITEM_BITS-1:0] left_d,
	input  logic [ITEM_BITS-1:0] right_d,
	input  logic [ITEM_BITS-1:0] right_p,
	output logic [ITEM_BITS-1:0] data,
	output logic [ITEM_BITS-1:0] probe
);

	localparam logic [CTL_W-1:0] ME      = CTL_W'(IDX);
	localparam logic [CTL_W-1:0] ME_NEXT = CTL_W'(IDX + 1);
	localparam bit               IS_HEAD = (IDX == 0);

	logic [ITEM_BITS-1:0] data_q;
	logic [ITEM_BITS-1:0] probe_q;
	logic [ITEM_BITS-1:0] data_n;
	logic [ITEM_BITS-1:0] probe_n;
	logic                 pair_up;

	assign pair_up = ~(ME[0] ^ ctl.odd);

	always_comb begin
		data_n = data_q;
		case (ctl.mode)
			MODE_INSERT: begin
				if (ME > ctl.at) data_n = left_d;
				else if (ME == ctl.at) data_n = item;
			end
			MODE_REMOVE: begin
				if (ME >= ctl.at) data_n = right_d;
			end
			MODE_ROTATE: begin
				if (ME < ctl.tail) data_n = right_d;
				else if (ME == ctl.tail) data_n = head_d;
			end
			MODE_SWAP: begin
				if (ME >= ctl.lo && ME < ctl.hi) begin
					if (pair_up) begin
						if (ME_NEXT < ctl.hi) data_n = right_d;
					end else if (ME > ctl.lo) begin
						data_n = left_d;
					end
				end
			end
			default: data_n = data_q;
		endcase
	end

	always_comb begin
		if (ctl.load) probe_n = (ctl.pick && ME == ctl.at) ? data_q : '0;
		else probe_n = right_p | (IS_HEAD ? probe_q : '0);
	end

	always_ff @(posedge clk) begin
		data_q  <= data_n;
		probe_q <= probe_n;
	end

	assign data  = data_q;
	assign probe = probe_q;

endmodule

FILE: design/deque_positional_reverse.sv
`timescale 1ns / 1ps

// Bounded deque of DEPTH item words kept in logical order in a row of cells. A command is
// taken when start is high and busy is low. Its result appears on rsp for exactly one
// cycle, marked by done, once the run state ends, and cannot be held off. Busy stays high
// through the done cycle, so the next command may be taken only after the done cycle ends,
// and every command passes through the same run of states whatever its operation. The run
// length is set by the row: a removed word walks one cell per cycle to the front cell to
// be returned, and a reversal runs up to DEPTH passes of neighbor swaps between alternate
// cell pairs.
module deque_positional_reverse import dpr_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int ITEM_BITS = ITEM_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	localparam logic [IDX_W-1:0] LAST_ROUND = IDX_W'(DEPTH - 1);
	localparam logic [CTL_W-1:0] DEPTH_C    = CTL_W'(DEPTH);

	logic [1:0]       state_q;
	logic [IDX_W-1:0] round_q;
	logic [CNT_W-1:0] fill_q;

	logic [2:0]           mode0_q;
	logic [CTL_W-1:0]     at_q;
	logic [CTL_W-1:0]     tail_q;
	logic [CTL_W-1:0]     lo_q;
	logic [CTL_W-1:0]     hi_q;
	logic [CTL_W-1:0]     span_q;
	logic                 pick_q;
	logic [1:0]           status_q;
	logic [ITEM_BITS-1:0] push_q;

	logic                 accept;
	logic [CTL_W-1:0]     n_c;
	logic [CTL_W-1:0]     pos_c;
	logic [CTL_W-1:0]     k_c;
	logic [ITEM_BITS+31:0] item_x;
	logic [ITEM_BITS-1:0] item_w;

	logic [2:0]           mode_d;
	logic [CTL_W-1:0]     at_d;
	logic [CTL_W-1:0]     lo_d;
	logic [CTL_W-1:0]     hi_d;
	logic                 pick_d;
	logic [1:0]           status_d;
	logic [CTL_W-1:0]     n_d;
	logic [ITEM_BITS-1:0] push_d;

	ctl_t ctl;

	logic [ITEM_BITS-1:0] cell_d [DEPTH];
	logic [ITEM_BITS-1:0] cell_p [DEPTH];
	logic [ITEM_BITS-1:0] left_d [DEPTH];
	logic [ITEM_BITS-1:0] right_d [DEPTH];
	logic [ITEM_BITS-1:0] right_p [DEPTH];

	logic [ITEM_BITS+31:0] touched_x;
	logic [CNT_W+6:0]      length_x;

	assign accept = start && !busy;
	assign n_c    = CTL_W'(fill_q);
	assign pos_c  = CTL_W'(cmd.position);
	assign k_c    = CTL_W'(cmd.span);
	assign item_x = {{ITEM_BITS{1'b0}}, cmd.item};
	assign item_w = item_x[ITEM_BITS-1:0];

	always_comb begin
		mode_d   = MODE_HOLD;
		at_d     = '0;
		lo_d     = '0;
		hi_d     = '0;
		pick_d   = 1'b0;
		status_d = ST_OK;
		n_d      = n_c;
		push_d   = '0;
		case (cmd.op)
			OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
				if (n_c == DEPTH_C) begin
					status_d = ST_FULL;
				end else begin
					mode_d = MODE_INSERT;
					push_d = item_w;
					n_d    = n_c + 1'b1;
					case (cmd.op)
						OP_PUSH_FRONT: at_d = '0;
						OP_PUSH_BACK:  at_d = n_c;
						default:       at_d = (pos_c < n_c) ? pos_c : n_c;
					endcase
				end
			end
			OP_POP_FRONT, OP_POP_BACK, OP_REMOVE, OP_ROTATE: begin
				if (n_c == '0) begin
					status_d = ST_EMPTY;
				end else begin
					pick_d = 1'b1;
					mode_d = MODE_REMOVE;
					n_d    = n_c - 1'b1;
					case (cmd.op)
						OP_POP_BACK: at_d = n_c - 1'b1;
						OP_REMOVE:   at_d = (pos_c < n_c - 1'b1) ? pos_c : n_c - 1'b1;
						OP_ROTATE: begin
							mode_d = MODE_ROTATE;
							n_d    = n_c;
						end
						default:     at_d = '0;
					endcase
				end
			end
			OP_REV_FRONT, OP_REV_BACK: begin
				if (k_c != '0 && n_c > CTL_W'(1)) begin
					mode_d = MODE_SWAP;
					if (k_c >= n_c) begin
						hi_d = n_c;
					end else if (cmd.op == OP_REV_FRONT) begin
						hi_d = k_c;
					end else begin
						lo_d = n_c - k_c;
						hi_d = n_c;
					end
				end
			end
			default: mode_d = MODE_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			round_q <= '0;
			fill_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RUN;
						round_q <= '0;
						fill_q  <= n_d[CNT_W-1:0];
					end
				end
				S_RUN: begin
					round_q <= round_q + 1'b1;
					if (round_q == LAST_ROUND) state_q <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode0_q  <= mode_d;
			at_q     <= at_d;
			tail_q   <= n_c - 1'b1;
			lo_q     <= lo_d;
			hi_q     <= hi_d;
			span_q   <= hi_d - lo_d;
			pick_q   <= pick_d;
			status_q <= status_d;
			push_q   <= push_d;
		end
	end

	always_comb begin
		ctl.mode = MODE_HOLD;
		ctl.at   = at_q;
		ctl.tail = tail_q;
		ctl.lo   = lo_q;
		ctl.hi   = hi_q;
		ctl.odd  = lo_q[0] ^ round_q[0];
		ctl.pick = pick_q;
		ctl.load = (state_q == S_RUN) && (round_q == '0);
		if (state_q == S_RUN) begin
			if (mode0_q == MODE_SWAP) begin
				if (CTL_W'(round_q) < span_q) ctl.mode = MODE_SWAP;
			end else if (round_q == '0) begin
				ctl.mode = mode0_q;
			end
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_d[i] = cell_d[i];
		end else begin : g_mid
			assign left_d[i] = cell_d[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d[i] = cell_d[i];
			assign right_p[i] = '0;
		end else begin : g_inner
			assign right_d[i] = cell_d[i+1];
			assign right_p[i] = cell_p[i+1];
		end

		dpr_cell #(
			.IDX       (i),
			.ITEM_BITS (ITEM_BITS)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.item    (push_q),
			.head_d  (cell_d[0]),
			.left_d  (left_d[i]),
			.right_d (right_d[i]),
			.right_p (right_p[i]),
			.data    (cell_d[i]),
			.probe   (cell_p[i])
		);
	end

	assign touched_x = {32'b0, cell_p[0] | push_q};
	assign length_x  = {7'b0, fill_q};

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	assign rsp.touched_item = touched_x[31:0];
	assign rsp.status       = status_q;
	assign rsp.length       = length_x[6:0];

endmodule

FILE: design/dpr_checker.sv
`timescale 1ns / 1ps

module dpr_checker import dpr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("Accepted word did not make the block busy.");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("Result strobe while not busy.");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("Result strobe held for more than one cycle.");

	a_empty_length: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_EMPTY |-> rsp.length == 7'd0)
		else $error("Empty status with a nonzero length.");

endmodule

bind deque_positional_reverse dpr_checker u_dpr_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
